### src/lmsfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfb_pkg: shared definitions for the serpentine sprite framebuffer
// Operation codes, sizes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package lmsfb_pkg;

  localparam int unsigned SIDE_DEFAULT = 16;
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned FUNC_W       = 3;

  localparam logic [FUNC_W-1:0] FN_SET_BG  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FILL    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SPRITE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_PIX = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RESTORE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd5;

  // Source of the next result loaded into the output register.
  typedef enum logic [1:0] {
    OUT_ITEM,
    OUT_READ,
    OUT_SWEEP
  } out_src_e;

  typedef struct packed {
    logic     accept;
    logic     fill_we;
    logic     fill_zero;
    logic     copy_rd;
    logic     out_load;
    out_src_e out_src;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
  } status_t;

endpackage

### src/lmsfb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfb_datapath: frame stores, address generation and result register
// Holds both frame memories, the sweep counter and the output payload.
// ----------------------------------------------------------------------------
module lmsfb_datapath
  import lmsfb_pkg::*;
#(
  parameter int unsigned SIDE = SIDE_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [3:0]          pos_x_i,
  input  logic [3:0]          pos_y_i,
  input  logic signed [7:0]   offset_x_i,
  input  logic signed [7:0]   offset_y_i,
  input  logic [COLOR_W-1:0]  pixel_color_i,
  input  logic [7:0]          strip_index_i,
  output logic [COLOR_W-1:0]  pixel_out_o,
  output logic                written_o
);

  localparam int unsigned CELLS = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(SIDE);
  localparam logic signed [9:0] SIDE_S = 10'(SIDE);
  localparam logic [AW-1:0]     LAST   = AW'(CELLS - 1);
  localparam logic [XW-1:0]     MAXC   = XW'(SIDE - 1);

  logic [COLOR_W-1:0] bg_mem [CELLS];
  logic [COLOR_W-1:0] mf_mem [CELLS];

  logic [AW-1:0]      cnt_q, cnt_d;
  logic               copy_wr_q;
  logic [AW-1:0]      copy_addr_q;
  logic [COLOR_W-1:0] bg_rdata_q;
  logic [COLOR_W-1:0] mf_rdata_q;
  logic               rd_ok_q;
  logic [COLOR_W-1:0] fill_color_q;
  logic [COLOR_W-1:0] pixel_out_q;
  logic               written_q;

  logic signed [9:0]  sx, sy;
  logic               on_screen, is_pix, wr_ok, rd_ok;
  logic [XW-1:0]      row, col;
  logic [AW-1:0]      pix_addr, rd_addr;
  logic [COLOR_W-1:0] fill_data;
  logic               bg_we, mf_we;
  logic [AW-1:0]      mf_waddr;
  logic [COLOR_W-1:0] mf_wdata;

  // Screen position: sprite pixels are shifted by the signed offset.
  always_comb begin
    sx = $signed({6'd0, pos_x_i});
    sy = $signed({6'd0, pos_y_i});
    if (func_i == FN_SPRITE) begin
      sx = sx + $signed({{2{offset_x_i[7]}}, offset_x_i});
      sy = sy + $signed({{2{offset_y_i[7]}}, offset_y_i});
    end
  end

  assign on_screen = (sx >= 10'sd0) && (sx < SIDE_S) && (sy >= 10'sd0) && (sy < SIDE_S);
  assign is_pix    = (func_i == FN_SET_BG) || (func_i == FN_SET_PIX) ||
                     ((func_i == FN_SPRITE) && (pixel_color_i != '0));
  assign wr_ok     = is_pix && on_screen;

  // Serpentine mapping: screen row y is strip row SIDE-1-y, odd rows reversed.
  assign row      = MAXC - sy[XW-1:0];
  assign col      = row[0] ? (MAXC - sx[XW-1:0]) : sx[XW-1:0];
  assign pix_addr = AW'(int'(row) * SIDE + int'(col));

  assign rd_addr  = AW'(strip_index_i);
  assign rd_ok    = ({24'd0, strip_index_i} < 32'(CELLS));

  assign fill_data = cmd_i.fill_zero ? '0 : fill_color_q;

  assign bg_we = cmd_i.fill_we || (cmd_i.accept && (func_i == FN_SET_BG) && wr_ok);
  assign mf_we = cmd_i.fill_we || copy_wr_q || (cmd_i.accept && wr_ok);

  always_comb begin
    if (cmd_i.fill_we) begin
      mf_waddr = cnt_q;
      mf_wdata = fill_data;
    end else if (copy_wr_q) begin
      mf_waddr = copy_addr_q;
      mf_wdata = bg_rdata_q;
    end else begin
      mf_waddr = pix_addr;
      mf_wdata = pixel_color_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bg_we) begin
      bg_mem[cmd_i.fill_we ? cnt_q : pix_addr] <= cmd_i.fill_we ? fill_data : pixel_color_i;
    end
    if (cmd_i.copy_rd) begin
      bg_rdata_q <= bg_mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mf_we) begin
      mf_mem[mf_waddr] <= mf_wdata;
    end
    if (cmd_i.accept && (func_i == FN_READ)) begin
      mf_rdata_q <= mf_mem[rd_addr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.accept) begin
      cnt_d = '0;
    end else if (cmd_i.fill_we || cmd_i.copy_rd) begin
      cnt_d = cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      copy_wr_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      copy_wr_q <= cmd_i.copy_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    copy_addr_q <= cnt_q;
    if (cmd_i.accept) begin
      rd_ok_q <= rd_ok;
      if (func_i == FN_FILL) begin
        fill_color_q <= pixel_color_i;
      end
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_src)
        OUT_ITEM: begin
          pixel_out_q <= '0;
          written_q   <= wr_ok;
        end
        OUT_READ: begin
          pixel_out_q <= rd_ok_q ? mf_rdata_q : '0;
          written_q   <= 1'b0;
        end
        OUT_SWEEP: begin
          pixel_out_q <= '0;
          written_q   <= 1'b1;
        end
        default: begin
          pixel_out_q <= '0;
          written_q   <= 1'b0;
        end
      endcase
    end
  end

  assign status_o.cnt_last = (cnt_q == LAST);
  assign pixel_out_o       = pixel_out_q;
  assign written_o         = written_q;

endmodule

### src/lmsfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsfb_ctrl: sequencing state machine
// Runs the clearing pass, the fill and restore sweeps and the handshakes.
// ----------------------------------------------------------------------------
module lmsfb_ctrl
  import lmsfb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmd_t              cmd_o,
  input  status_t           status_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_COPY,
    S_DRAIN,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d         = state_q;
    cmd_o.accept    = 1'b0;
    cmd_o.fill_we   = 1'b0;
    cmd_o.fill_zero = 1'b0;
    cmd_o.copy_rd   = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.out_src   = OUT_ITEM;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.fill_we   = 1'b1;
        cmd_o.fill_zero = 1'b1;
        if (status_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          if (func_i == FN_FILL) begin
            state_d = S_FILL;
          end else if (func_i == FN_RESTORE) begin
            state_d = S_COPY;
          end else if (func_i == FN_READ) begin
            state_d = S_READ;
          end else begin
            cmd_o.out_load = 1'b1;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_we = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = OUT_SWEEP;
          state_d        = S_IDLE;
        end
      end
      S_COPY: begin
        cmd_o.copy_rd = 1'b1;
        if (status_i.cnt_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_src  = OUT_SWEEP;
        state_d        = S_IDLE;
      end
      S_READ: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_src  = OUT_READ;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/led_matrix_sprite_framebuffer.sv
`timescale 1ns / 1ps
// Pixel writes (set, sprite, unused codes) give their result in the cycle after transfer.
// Reads pass through the registered frame memory port and then the result register.
// Fill and restore sweep all SIDE*SIDE entries, one memory entry per cycle.
// Throughput: one pixel write per cycle while results are taken; reads block new items while in flight.
// Reset: a clearing pass over all SIDE*SIDE entries (256 by default) zeroes both frames first.
// ----------------------------------------------------------------------------
// led_matrix_sprite_framebuffer: serpentine 24-bit sprite framebuffer
// Background and main frame stores with sprite drawing, fill, restore and read.
// ----------------------------------------------------------------------------
module led_matrix_sprite_framebuffer
  import lmsfb_pkg::*;
#(
  parameter int unsigned SIDE = SIDE_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [3:0]          pos_x_i,
  input  logic [3:0]          pos_y_i,
  input  logic signed [7:0]   offset_x_i,
  input  logic signed [7:0]   offset_y_i,
  input  logic [COLOR_W-1:0]  pixel_color_i,
  input  logic [7:0]          strip_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COLOR_W-1:0]  pixel_out_o,
  output logic                written_o
);

  // The controller sequences every operation; the datapath owns both frame
  // memories, the sweep counter and the result register. A new transfer is
  // taken whenever the controller is idle and the result register is empty or
  // being emptied in the same cycle.
  cmd_t    cmd;
  status_t status;

  lmsfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Single-pixel writes go straight into the memories at the transfer edge;
  // fill and restore sweep the whole store, restore with a delayed
  // write because the background read is registered.
  lmsfb_datapath #(
    .SIDE(SIDE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .pixel_color_i(pixel_color_i),
    .strip_index_i(strip_index_i),
    .pixel_out_o  (pixel_out_o),
    .written_o    (written_o)
  );

  // Input is only taken when the result register can receive the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input taken while result register is blocked");

  // A read presents its result only after the frame memory read register and then the result register have been loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FN_READ)) |=> (!out_valid_o ##1 out_valid_o))
    else $error("read result timing wrong");

  // A pixel write presents its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FN_SET_PIX)) |=> out_valid_o)
    else $error("pixel write result missing");

  // Only reads return a colour, and reads never report a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (pixel_out_o != '0)) |-> !written_o)
    else $error("result carries both colour and write flag");

endmodule

### tb/sv/led_matrix_sprite_framebuffer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_sprite_framebuffer_test: self-checking bench for the framebuffer
// A stimulus table of corner cases is followed by weighted random operations.
// The bench keeps its own copy of both frames to predict every result, and it
// idles and stalls both channels at random.
// ----------------------------------------------------------------------------
module led_matrix_sprite_framebuffer_test;
  import lmsfb_pkg::*;

  localparam int unsigned SIDE  = SIDE_DEFAULT;
  localparam int unsigned CELLS = SIDE * SIDE;

  // The two func codes that the block leaves unused.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  localparam logic [COLOR_W-1:0] WHITE = '1;
  localparam logic [COLOR_W-1:0] BLACK = '0;

  localparam int RANDOM_ITEMS     = 1750;
  localparam int MAX_IDLE         = 17;
  localparam int BURST_LEN        = 40;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int FLOOD_ITEMS      = 60;
  localparam int HOLD_AT_ITEM     = 200;
  localparam int DRAIN_AT_ITEM    = 1000;
  // A restore is the slowest operation; allow two of them to run out.
  localparam int SETTLE_CYCLES    = 2 * CELLS + 16;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [3:0]         pos_x;
    logic [3:0]         pos_y;
    logic signed [7:0]  offset_x;
    logic signed [7:0]  offset_y;
    logic [COLOR_W-1:0] color;
    logic [7:0]         strip_index;
  } frame_op_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic               written;
  } frame_result_t;

  // One row of the stimulus table. Where known is set, the result is typed in
  // by hand; otherwise it comes from the frame predictor.
  typedef struct packed {
    frame_op_t     op;
    logic          known;
    frame_result_t result;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FUNC_W-1:0]  func_i;
  logic [3:0]         pos_x_i;
  logic [3:0]         pos_y_i;
  logic signed [7:0]  offset_x_i;
  logic signed [7:0]  offset_y_i;
  logic [COLOR_W-1:0] pixel_color_i;
  logic [7:0]         strip_index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [COLOR_W-1:0] pixel_out_o;
  logic               written_o;

  // The bench's own copy of both frames, in strip order.
  logic [COLOR_W-1:0] bg_frame    [CELLS];
  logic [COLOR_W-1:0] front_frame [CELLS];

  frame_result_t pending_results [$];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  items_sent     = 0;
  int  op_count [8];
  int  sprite_drawn   = 0;
  int  sprite_skipped = 0;
  bit  sink_hold_req  = 1'b0;

  led_matrix_sprite_framebuffer #(
    .SIDE(SIDE)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .offset_x_i    (offset_x_i),
    .offset_y_i    (offset_y_i),
    .pixel_color_i (pixel_color_i),
    .strip_index_i (strip_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .written_o     (written_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Screen row y lives on strip row SIDE-1-y, and odd strip rows run from
  // right to left.
  function automatic int strip_pos(input int x, input int y);
    int row;
    row = SIDE - 1 - y;
    if (row % 2 == 1) begin
      return row * SIDE + (SIDE - 1 - x);
    end
    return row * SIDE + x;
  endfunction

  // Applies one operation to the bench's frames and returns what the block
  // should answer for it.
  function automatic frame_result_t apply_frame_op(input frame_op_t op);
    frame_result_t res;
    int            sx;
    int            sy;
    int            idx;
    res = '0;
    case (op.func)
      FN_SET_BG: begin
        if (op.pos_x < SIDE && op.pos_y < SIDE) begin
          idx = strip_pos(op.pos_x, op.pos_y);
          bg_frame[idx]    = op.color;
          front_frame[idx] = op.color;
          res.written      = 1'b1;
        end
      end
      FN_FILL: begin
        for (int i = 0; i < CELLS; i++) begin
          bg_frame[i]    = op.color;
          front_frame[i] = op.color;
        end
        res.written = 1'b1;
      end
      FN_SPRITE: begin
        sx = int'(op.pos_x) + int'(op.offset_x);
        sy = int'(op.pos_y) + int'(op.offset_y);
        if (op.color != BLACK && sx >= 0 && sx < SIDE && sy >= 0 && sy < SIDE) begin
          front_frame[strip_pos(sx, sy)] = op.color;
          res.written = 1'b1;
        end
      end
      FN_SET_PIX: begin
        if (op.pos_x < SIDE && op.pos_y < SIDE) begin
          front_frame[strip_pos(op.pos_x, op.pos_y)] = op.color;
          res.written = 1'b1;
        end
      end
      FN_RESTORE: begin
        for (int i = 0; i < CELLS; i++) begin
          front_frame[i] = bg_frame[i];
        end
        res.written = 1'b1;
      end
      FN_READ: begin
        if (op.strip_index < CELLS) begin
          res.pixel = front_frame[op.strip_index];
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic stim_row_t make_row(
    input logic [FUNC_W-1:0]  func,
    input logic [3:0]         px,
    input logic [3:0]         py,
    input logic signed [7:0]  ox,
    input logic signed [7:0]  oy,
    input logic [COLOR_W-1:0] color,
    input logic [7:0]         sidx,
    input logic               known,
    input logic [COLOR_W-1:0] pix,
    input logic               wr
  );
    stim_row_t r;
    r.op.func        = func;
    r.op.pos_x       = px;
    r.op.pos_y       = py;
    r.op.offset_x    = ox;
    r.op.offset_y    = oy;
    r.op.color       = color;
    r.op.strip_index = sidx;
    r.known          = known;
    r.result.pixel   = pix;
    r.result.written = wr;
    return r;
  endfunction

  // Offers one item after an idle gap (or after the block has drained) and
  // waits for its transfer. The expectation is queued at the transfer edge,
  // so reads see the frames exactly as the block does.
  task automatic offer_item(input stim_row_t r, input int gap, input bit drain);
    frame_result_t predicted;
    if (gap > 0 || drain) begin
      in_valid_i <= 1'b0;
      if (drain) begin
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      repeat (gap) @(posedge clk_i);
    end
    func_i        <= r.op.func;
    pos_x_i       <= r.op.pos_x;
    pos_y_i       <= r.op.pos_y;
    offset_x_i    <= r.op.offset_x;
    offset_y_i    <= r.op.offset_y;
    pixel_color_i <= r.op.color;
    strip_index_i <= r.op.strip_index;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_frame_op(r.op);
    pending_results.push_back(r.known ? r.result : predicted);
    items_sent++;
    op_count[r.op.func]++;
    if (r.op.func == FN_SPRITE) begin
      if (predicted.written) sprite_drawn++;
      else sprite_skipped++;
    end
  endtask

  initial begin : stimulus
    stim_row_t directed_rows [$];
    stim_row_t row;
    int        gap;
    int        burst_left;
    bit        idle_on;
    int        flood_left;
    int        sel;
    int        tmp;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FN_READ;
    pos_x_i       = '0;
    pos_y_i       = '0;
    offset_x_i    = '0;
    offset_y_i    = '0;
    pixel_color_i = '0;
    strip_index_i = '0;
    for (int i = 0; i < CELLS; i++) begin
      bg_frame[i]    = '0;
      front_frame[i] = '0;
    end
    for (int i = 0; i < 8; i++) op_count[i] = 0;

    // Both frames start out black.
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd0, 1, BLACK, 0));
    directed_rows.push_back(make_row(FN_READ, 15, 15, -1, -1, WHITE, 8'd255, 1, BLACK, 0));
    // Unused codes change nothing and report nothing.
    directed_rows.push_back(make_row(FN_SPARE_LO, 3, 4, 1, 1, 24'h5a5a5a, 8'd7, 1, BLACK, 0));
    directed_rows.push_back(make_row(FN_SPARE_HI, 15, 15, -1, -1, WHITE, 8'd255, 1, BLACK, 0));
    // Corner pixels on both frames, then read back in strip order.
    directed_rows.push_back(make_row(FN_SET_BG, 0, 0, 0, 0, 24'h123456, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd255, 0, BLACK, 0));
    directed_rows.push_back(make_row(FN_SET_PIX, 15, 15, 0, 0, WHITE, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd15, 0, BLACK, 0));
    // A transparent sprite pixel is skipped.
    directed_rows.push_back(make_row(FN_SPRITE, 0, 0, 0, 0, BLACK, 0, 1, BLACK, 0));
    // Sprite pixels that land off-screen on either side of either axis.
    directed_rows.push_back(make_row(FN_SPRITE, 15, 0, 127, 0, WHITE, 0, 1, BLACK, 0));
    directed_rows.push_back(make_row(FN_SPRITE, 0, 0, -128, 0, WHITE, 0, 1, BLACK, 0));
    directed_rows.push_back(make_row(FN_SPRITE, 0, 15, 0, 1, WHITE, 0, 1, BLACK, 0));
    directed_rows.push_back(make_row(FN_SPRITE, 5, 0, 0, -1, WHITE, 0, 1, BLACK, 0));
    // Sprite pixels that just reach the opposite corners.
    directed_rows.push_back(make_row(FN_SPRITE, 15, 15, -15, -15, 24'habcdef, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_SPRITE, 0, 0, 15, 15, 24'h000001, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd255, 0, BLACK, 0));
    // Restore drops the sprite and set-pixel writes again.
    directed_rows.push_back(make_row(FN_RESTORE, 0, 0, 0, 0, BLACK, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd255, 0, BLACK, 0));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd15, 0, BLACK, 0));
    // Fills with both extreme colours.
    directed_rows.push_back(make_row(FN_FILL, 0, 0, 0, 0, BLACK, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd128, 1, BLACK, 0));
    directed_rows.push_back(make_row(FN_FILL, 0, 0, 0, 0, WHITE, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_SET_BG, 7, 8, 0, 0, 24'h800000, 0, 1, BLACK, 1));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd120, 0, BLACK, 0));
    directed_rows.push_back(make_row(FN_READ, 0, 0, 0, 0, BLACK, 8'd0, 1, WHITE, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first item simply waits out the clearing pass after reset.
    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i], (i % 3 == 0) ? int'($urandom_range(MAX_IDLE)) : 0,
                 1'b0);
    end

    burst_left = 0;
    idle_on    = 1'b0;
    flood_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row       = '0;
      row.op.pos_x       = 4'($urandom);
      row.op.pos_y       = 4'($urandom);
      row.op.offset_x    = 8'($urandom);
      row.op.offset_y    = 8'($urandom);
      row.op.color       = 24'($urandom);
      row.op.strip_index = 8'($urandom);
      sel = $urandom_range(99);
      if (sel < 35) begin
        row.op.func = FN_SPRITE;
        // Most sprite pixels are placed so that they may land on screen.
        if ($urandom_range(3) != 0) begin
          tmp = int'($urandom_range(30)) - 15;
          row.op.offset_x = 8'(tmp);
          tmp = int'($urandom_range(30)) - 15;
          row.op.offset_y = 8'(tmp);
        end
        if ($urandom_range(9) == 0) row.op.color = BLACK;
      end else if (sel < 50) begin
        row.op.func = FN_SET_PIX;
      end else if (sel < 64) begin
        row.op.func = FN_SET_BG;
      end else if (sel < 90) begin
        row.op.func = FN_READ;
      end else if (sel < 93) begin
        row.op.func = FN_FILL;
        if ($urandom_range(3) == 0) row.op.color = $urandom_range(1) ? WHITE : BLACK;
      end else if (sel < 97) begin
        row.op.func = FN_RESTORE;
      end else begin
        row.op.func = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
      end

      if (burst_left == 0) begin
        burst_left = BURST_LEN;
        idle_on    = 1'($urandom_range(1));
      end
      burst_left--;

      // Once, stall the result side for a long stretch while items keep coming,
      // so that the block fills up and holds off further transfers.
      if (n == HOLD_AT_ITEM) begin
        sink_hold_req = 1'b1;
        flood_left    = FLOOD_ITEMS;
      end

      if (flood_left > 0) begin
        flood_left--;
        gap = 0;
      end else begin
        gap = idle_on ? int'($urandom_range(MAX_IDLE)) : 0;
      end
      offer_item(row, gap, n == DRAIN_AT_ITEM);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d items and %0d results: %0d background sets, %0d fills, %0d restores,",
             items_sent, results_seen, op_count[FN_SET_BG], op_count[FN_FILL],
             op_count[FN_RESTORE]);
    $display("  %0d pixel sets, %0d reads, %0d sprite pixels drawn, %0d skipped, %0d unused codes.",
             op_count[FN_SET_PIX], op_count[FN_READ], sprite_drawn, sprite_skipped,
             op_count[FN_SPARE_LO] + op_count[FN_SPARE_HI]);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: stalls for a random number of cycles before each transfer,
  // in bursts with and without stalling, plus one long hold-off on request.
  initial begin : result_sink
    int  stall;
    int  burst_left;
    bit  stall_on;
    bit  hold_done;
    out_ready_i = 1'b0;
    burst_left  = 0;
    stall_on    = 1'b0;
    hold_done   = 1'b0;
    @(posedge clk_i);
    forever begin
      if (burst_left == 0) begin
        burst_left = BURST_LEN;
        stall_on   = 1'($urandom_range(1));
      end
      burst_left--;
      stall = stall_on ? int'($urandom_range(MAX_IDLE)) : 0;
      if (sink_hold_req && !hold_done) begin
        hold_done = 1'b1;
        stall     = SINK_HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Every result transfer is compared field by field with the oldest
  // expectation still waiting.
  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: pixel_out %06h, written %0b", pixel_out_o, written_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (pixel_out_o !== want.pixel) begin
          $error("pixel_out mismatch: expected %06h, got %06h", want.pixel, pixel_out_o);
          mismatch_count++;
        end
        if (written_o !== want.written) begin
          $error("written mismatch: expected %0b, got %0b", want.written, written_o);
          mismatch_count++;
        end
      end
    end
  end

  // Hard limit, far beyond the slowest correct run.
  initial begin : run_limit
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
